// ----- design/cfc_pkg.sv -----
package cfc_pkg;

    // framing and crc constants
    localparam logic [15:0] CRC_POLY      = 16'h1021;
    localparam logic [15:0] CRC_TOP       = 16'h8000;
    localparam logic [15:0] CRC_INIT      = 16'h0000;
    localparam logic [7:0]  CHAR_PAREN    = 8'h28;
    localparam logic [7:0]  CHAR_CR       = 8'h0D;
    localparam logic [7:0]  CHAR_LF       = 8'h0A;

    // receive buffer size bounding the length limit
    localparam int          BUFFER_BYTES  = 512;

    // register reset values
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [9:0]  MAXLEN_RESET  = 10'd512;

    // queue between front and back
    localparam int          QUEUE_DEPTH   = 2;

    // register indexes
    localparam logic        CFG_TIMEOUT   = 1'b0;
    localparam logic        CFG_MAXLEN    = 1'b1;

    // input command codes
    localparam logic [1:0]  CMD_START     = 2'd0;
    localparam logic [1:0]  CMD_BYTE      = 2'd1;
    localparam logic [1:0]  CMD_TICK      = 2'd2;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_BYTE,
        KIND_TICK,
        KIND_NONE
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NORESP     = 3'd1,
        ST_INCOMPLETE = 3'd2,
        ST_SHORT      = 3'd3,
        ST_CRCBAD     = 3'd4,
        ST_NOPAREN    = 3'd5
    } status_t;

    // classified item in the queue
    typedef struct packed {
        kind_t       kind;
        logic        is_cr;
        logic [7:0]  data;
    } item_t;

    // one result item
    typedef struct packed {
        logic        is_status;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic [8:0]  payload_length;
    } result_t;

    // configuration register values
    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [9:0]  max_length;
    } cfg_t;

    // crc-16 xmodem update by one byte, msb first
    function automatic logic [15:0] fold_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // reserved characters are raised by one
    function automatic logic [7:0] bump_reserved(input logic [7:0] b);
        if (b == CHAR_PAREN || b == CHAR_CR || b == CHAR_LF)
            return b + 8'd1;
        return b;
    endfunction

endpackage

// ----- design/cfc_front.sv -----
module cfc_front (
    input  logic               s_tvalid,
    input  logic [1:0]         cmd,
    input  logic [7:0]         data_byte,
    input  logic               queue_full,
    output logic               s_tready,
    output logic               push,
    output cfc_pkg::item_t     item
);

    // classify the command and flag carriage return
    always_comb
    begin
        item.data  = data_byte;
        item.is_cr = (data_byte == cfc_pkg::CHAR_CR);
        case (cmd)
            cfc_pkg::CMD_START: item.kind = cfc_pkg::KIND_START;
            cfc_pkg::CMD_BYTE:  item.kind = cfc_pkg::KIND_BYTE;
            cfc_pkg::CMD_TICK:  item.kind = cfc_pkg::KIND_TICK;
            default:            item.kind = cfc_pkg::KIND_NONE;
        endcase
    end

    // unused codes are taken but never queued
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full && (item.kind != cfc_pkg::KIND_NONE);

endmodule

// ----- design/cfc_fifo.sv -----
module cfc_fifo #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- design/cfc_back.sv -----
module cfc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cfc_pkg::cfg_t      cfg,
    input  cfc_pkg::item_t     item,
    input  logic               queue_empty,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output cfc_pkg::result_t   out_item
);

    // limit in use is the smaller of max_length and the buffer size
    localparam logic [9:0] BUF_LIM =
        (cfc_pkg::BUFFER_BYTES > 1023) ? 10'd1023 : 10'(cfc_pkg::BUFFER_BYTES);

    logic             active_reg, active_next;
    logic [9:0]       count_reg, count_next;
    logic [7:0]       hold0_reg, hold0_next;
    logic [7:0]       hold1_reg, hold1_next;
    logic [1:0]       fill_reg, fill_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       first_reg, first_next;
    logic [15:0]      elapsed_reg, elapsed_next;
    logic             out_valid_reg, out_valid_next;
    cfc_pkg::result_t out_reg, out_next;

    logic             res_valid;
    cfc_pkg::result_t res;
    logic [9:0]       limit;
    logic [9:0]       left;
    logic [9:0]       emitted;
    logic [15:0]      el_inc;
    logic [15:0]      rc, cc;

    assign limit   = (cfg.max_length < BUF_LIM) ? cfg.max_length : BUF_LIM;
    assign left    = (count_reg >= {8'h00, fill_reg}) ? count_reg - {8'h00, fill_reg} : 10'd0;
    assign emitted = (left != 10'd0) ? left - 10'd1 : 10'd0;
    assign el_inc  = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign rc      = {hold0_reg, hold1_reg};
    assign cc      = {cfc_pkg::bump_reserved(crc_reg[15:8]),
                      cfc_pkg::bump_reserved(crc_reg[7:0])};

    // take the next item when the output slot frees up
    assign pop = !queue_empty && (!out_valid_reg || out_ready);

    // execute one item
    always_comb
    begin
        active_next  = active_reg;
        count_next   = count_reg;
        hold0_next   = hold0_reg;
        hold1_next   = hold1_reg;
        fill_next    = fill_reg;
        crc_next     = crc_reg;
        first_next   = first_reg;
        elapsed_next = elapsed_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (pop)
        begin
            case (item.kind)
                cfc_pkg::KIND_START:
                begin
                    active_next  = 1'b1;
                    count_next   = '0;
                    hold0_next   = '0;
                    hold1_next   = '0;
                    fill_next    = '0;
                    crc_next     = cfc_pkg::CRC_INIT;
                    first_next   = '0;
                    elapsed_next = '0;
                end
                cfc_pkg::KIND_TICK:
                begin
                    if (active_reg)
                    begin
                        elapsed_next = el_inc;
                        if (el_inc >= cfg.timeout_ticks)
                        begin
                            res_valid          = 1'b1;
                            res.is_status      = 1'b1;
                            res.status         = (count_reg == 10'd0) ?
                                                 cfc_pkg::ST_NORESP : cfc_pkg::ST_INCOMPLETE;
                            res.payload_length = emitted[8:0];
                            active_next        = 1'b0;
                        end
                    end
                end
                cfc_pkg::KIND_BYTE:
                begin
                    if (active_reg)
                    begin
                        if (item.is_cr)
                        begin
                            // end of frame: length, crc, then paren
                            count_next         = count_reg + 10'd1;
                            res_valid          = 1'b1;
                            res.is_status      = 1'b1;
                            res.payload_length = emitted[8:0];
                            active_next        = 1'b0;
                            if (count_reg < 10'd3)
                                res.status = cfc_pkg::ST_SHORT;
                            else
                            begin
                                res.received_crc = rc;
                                res.computed_crc = cc;
                                if (rc != cc)
                                    res.status = cfc_pkg::ST_CRCBAD;
                                else if (first_reg != cfc_pkg::CHAR_PAREN)
                                    res.status = cfc_pkg::ST_NOPAREN;
                                else
                                    res.status = cfc_pkg::ST_OK;
                            end
                        end
                        else if ({1'b0, count_reg} + 11'd1 >= {1'b0, limit})
                        begin
                            // length limit reached by a data byte
                            count_next         = count_reg + 10'd1;
                            res_valid          = 1'b1;
                            res.is_status      = 1'b1;
                            res.status         = cfc_pkg::ST_INCOMPLETE;
                            res.payload_length = emitted[8:0];
                            active_next        = 1'b0;
                        end
                        else
                        begin
                            count_next = count_reg + 10'd1;
                            if (count_reg == 10'd0)
                                first_next = item.data;
                            if (fill_reg == 2'd2)
                            begin
                                // oldest held byte leaves into the crc
                                crc_next   = cfc_pkg::fold_byte(crc_reg, hold0_reg);
                                hold0_next = hold1_reg;
                                hold1_next = item.data;
                                if (count_reg != 10'd2)
                                begin
                                    res_valid        = 1'b1;
                                    res.payload_byte = hold0_reg;
                                end
                            end
                            else
                            begin
                                if (fill_reg[0])
                                    hold1_next = item.data;
                                else
                                    hold0_next = item.data;
                                fill_next = fill_reg + 2'd1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        if (pop)
        begin
            out_valid_next = res_valid;
            if (res_valid)
                out_next = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg   <= count_next;
        hold0_reg   <= hold0_next;
        hold1_reg   <= hold1_next;
        fill_reg    <= fill_next;
        crc_reg     <= crc_next;
        first_reg   <= first_next;
        elapsed_reg <= elapsed_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTH
    // holdback never fills past two bytes
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (fill_reg <= 2'd2))
        else $error("holdback fill out of range");

    // while the holdback fills, every counted byte sits in it
    a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && fill_reg != 2'd2) |-> (count_reg == {8'h00, fill_reg}))
        else $error("byte count and holdback fill disagree");

    // a status result closes the window
    a_status_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_valid && res.is_status) |=> !active_reg)
        else $error("window still open after status");

    // a payload result comes only from a full holdback
    a_payload_full: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && res_valid && !res.is_status) |-> (fill_reg == 2'd2))
        else $error("payload byte without full holdback");
`endif

endmodule

// ----- design/crc_framed_response_checker_top.sv -----
// channel  | direction | handshake          | content
// s        | in        | s_tvalid/s_tready  | s_tuser: cmd, s_tdata: data_byte
// m        | out       | m_tvalid/m_tready  | m_tlast: is_status, m_tdata: result fields
// cfg      | in        | cfg_we             | cfg_index, cfg_data
//
// one item per cycle sustained while m is not stalled; the back end folds a full byte into the crc
// combinationally, so the execute stage never holds an item back for more work
// an accepted item is written into the queue, then its result into the output register
// a queue of QUEUE_DEPTH items lets the input side keep accepting while m is stalled
// rst_n is asynchronous, active low; it closes the window and empties queue and output
module crc_framed_response_checker_top #(
    parameter int QUEUE_DEPTH = cfc_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] payload_byte, [10:8] status,
                                   // [26:11] received_crc, [42:27] computed_crc,
                                   // [51:43] payload_length, [55:52] zero
    output logic        m_tlast,   // is_status
    // configuration writes
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int ITEM_W = $bits(cfc_pkg::item_t);

    cfc_pkg::cfg_t      cfg_reg, cfg_next;
    cfc_pkg::item_t     front_item;
    cfc_pkg::item_t     back_item;
    cfc_pkg::result_t   result;
    logic               push, pop, queue_full, queue_empty;
    logic [ITEM_W-1:0]  queue_rdata;

    // configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cfc_pkg::CFG_TIMEOUT: cfg_next.timeout_ticks = cfg_data;
                cfc_pkg::CFG_MAXLEN:  cfg_next.max_length = cfg_data[9:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= cfc_pkg::TIMEOUT_RESET;
            cfg_reg.max_length    <= cfc_pkg::MAXLEN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // classify incoming items
    cfc_front u_front (
        .s_tvalid   (s_tvalid),
        .cmd        (s_tuser),
        .data_byte  (s_tdata),
        .queue_full (queue_full),
        .s_tready   (s_tready),
        .push       (push),
        .item       (front_item)
    );

    // decoupling queue
    cfc_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .pop   (pop),
        .rdata (queue_rdata),
        .full  (queue_full),
        .empty (queue_empty)
    );

    assign back_item = cfc_pkg::item_t'(queue_rdata);

    // frame checking engine
    cfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item        (back_item),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_item    (result)
    );

    // pack result fields
    assign m_tlast = result.is_status;
    assign m_tdata = {4'b0000, result.payload_length, result.computed_crc,
                      result.received_crc, result.status, result.payload_byte};

endmodule
